// File: rtl/hue_value_histogram_obstacle_mask_assert.svh
// ----------------------------------------------------------------------------
// hue_value_histogram_obstacle_mask_assert.svh
// assertion macros used by the obstacle mask rtl
// ----------------------------------------------------------------------------
`ifndef HUE_VALUE_HISTOGRAM_OBSTACLE_MASK_ASSERT_SVH
`define HUE_VALUE_HISTOGRAM_OBSTACLE_MASK_ASSERT_SVH

// same-cycle implication
`define HVOM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HVOM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/hvom_pkg.sv
// ----------------------------------------------------------------------------
// hvom_pkg
// types and constants of the hue/value histogram obstacle mask
// ----------------------------------------------------------------------------
package hvom_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR    = 2'd0,
        OP_ACCUM    = 2'd1,
        OP_CLASSIFY = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC_WR,
        ST_CLS_MUL,
        ST_CLS_OUT
    } state_t;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 14;
    localparam logic [CFG_INDEX_W-1:0] CFG_HUE_THR   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VALUE_THR = 1'd1;

    localparam int HUE_THR_W   = 14;
    localparam int VALUE_THR_W = 7;
    localparam int PIX_W       = 8;

    // rarity scales: hue threshold in 1/100000, value threshold in 1/1000
    localparam int unsigned HUE_SCALE   = 100000;
    localparam int          HUE_SCALE_W = 17;
    localparam int unsigned VALUE_SCALE   = 1000;
    localparam int          VALUE_SCALE_W = 10;

    localparam logic [PIX_W-1:0] VALUE_CLAMP = 8'd254;
    localparam logic [PIX_W-1:0] VALUE_TOP   = 8'd255;
    localparam logic [7:0]       MASK_ON     = 8'd255;
    localparam logic [7:0]       MASK_OFF    = 8'd0;

endpackage

// File: rtl/hue_value_histogram_obstacle_mask.sv
// ----------------------------------------------------------------------------
// hue_value_histogram_obstacle_mask
// rare-color obstacle marking from hue and value histograms
// input channel (in_valid/in_stall): opcode, hue, value. clear empties both
// histograms and the pixel count. accumulate adds a pixel to its hue bin and
// value bin (each only when in range) with saturating counts. classify returns one item with
// hue_obstacle, value_obstacle and mask on the output channel (out_valid/out_stall).
// each histogram is a small synchronous memory with a registered read; every
// item reads its bin, then writes it back or feeds the compare.
// steps per item: clear acts on acceptance; accumulate reads, then writes back;
// classify reads, multiplies, then compares, and may wait for the output
// register; the bin read-modify-write sets this. in_stall is high while an
// item is in flight, so accesses never overlap and need no forwarding.
// a result held under out_stall blocks input only once a following classify
// is finishing. thresholds are to be written on cfg (always ready) only while
// idle; the user is bound by this, the block itself does not enforce it.
// reset empties the histograms (per-bin valid bits), the pixel count and the
// thresholds, and drops any pending result.
// ----------------------------------------------------------------------------
module hue_value_histogram_obstacle_mask #(
    parameter int HUE_BINS    = 10,
    parameter int VALUE_BINS  = 15,
    parameter int HUE_RANGE   = 180,
    parameter int VALUE_RANGE = 256,
    parameter int COUNT_BITS  = 20
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         opcode,
    input  logic [7:0]                         hue,
    input  logic [7:0]                         value,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               hue_obstacle,
    output logic                               value_obstacle,
    output logic [7:0]                         mask,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hvom_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [hvom_pkg::CFG_DATA_W-1:0]    cfg_data
);

`include "hue_value_histogram_obstacle_mask_assert.svh"

    localparam int HUE_AW = (HUE_BINS > 1) ? $clog2(HUE_BINS) : 1;
    localparam int VAL_AW = (VALUE_BINS > 1) ? $clog2(VALUE_BINS) : 1;

    // accumulate bin = floor(x / RANGE), x = pix * BINS < 2^14, via reciprocal
    localparam int          ACC_N     = 14;
    localparam int          ACC_SHIFT = ACC_N + 8;
    localparam int unsigned HUE_ARCP  = ((1 << ACC_SHIFT) + HUE_RANGE - 1) / HUE_RANGE;
    localparam int unsigned VAL_ARCP  = ((1 << ACC_SHIFT) + VALUE_RANGE - 1) / VALUE_RANGE;
    localparam int unsigned HUE_AMUL  = HUE_ARCP * HUE_BINS;
    localparam int unsigned VAL_AMUL  = VAL_ARCP * VALUE_BINS;
    localparam int          ACC_PW    = hvom_pkg::PIX_W + 26;
    localparam int          ACC_BW    = ACC_PW - ACC_SHIFT;

    // classify bin = floor(pix / BSIZE), pix < 2^8
    localparam int          HUE_BSIZE = (HUE_RANGE / HUE_BINS > 0) ? HUE_RANGE / HUE_BINS : 1;
    localparam int          VAL_BSIZE = (VALUE_RANGE / VALUE_BINS > 0) ?
                                        VALUE_RANGE / VALUE_BINS : 1;
    localparam int          CLS_SHIFT = 16;
    localparam int unsigned HUE_CRCP  = ((1 << CLS_SHIFT) + HUE_BSIZE - 1) / HUE_BSIZE;
    localparam int unsigned VAL_CRCP  = ((1 << CLS_SHIFT) + VAL_BSIZE - 1) / VAL_BSIZE;
    localparam int          CLS_PW    = hvom_pkg::PIX_W + CLS_SHIFT + 1;
    localparam int          CLS_BW    = CLS_PW - CLS_SHIFT;

    localparam int HUE_PW = COUNT_BITS + hvom_pkg::HUE_SCALE_W;
    localparam int VAL_PW = COUNT_BITS + hvom_pkg::VALUE_SCALE_W;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // histogram memories, bins not yet written since the last clear read as zero
    logic [COUNT_BITS-1:0]   hue_mem [HUE_BINS];
    logic [COUNT_BITS-1:0]   val_mem [VALUE_BINS];
    logic [HUE_BINS-1:0]     hue_vld_reg;
    logic [VALUE_BINS-1:0]   val_vld_reg;

    hvom_pkg::state_t        state_reg;
    hvom_pkg::state_t        state_next;

    logic [COUNT_BITS-1:0]   pixel_count_reg;
    logic [hvom_pkg::HUE_THR_W-1:0]   hue_thr_reg;
    logic [hvom_pkg::VALUE_THR_W-1:0] val_thr_reg;

    logic [HUE_AW-1:0]       hue_addr_reg;
    logic [VAL_AW-1:0]       val_addr_reg;
    logic                    hue_wen_reg;
    logic                    val_wen_reg;
    logic [COUNT_BITS-1:0]   hue_rd_reg;
    logic [COUNT_BITS-1:0]   val_rd_reg;
    logic                    hue_hit_reg;
    logic                    val_hit_reg;

    logic [HUE_PW-1:0]       hue_lhs_reg;
    logic [HUE_PW-1:0]       hue_rhs_reg;
    logic [VAL_PW-1:0]       val_lhs_reg;
    logic [VAL_PW-1:0]       val_rhs_reg;

    logic                    out_valid_reg;
    logic                    hue_obst_reg;
    logic                    val_obst_reg;
    logic [7:0]              mask_reg;

    logic                    in_accept;
    logic                    clear_go;
    logic                    acc_write;
    logic                    out_load;

    logic [ACC_PW-1:0]       hue_acc_prod;
    logic [ACC_PW-1:0]       val_acc_prod;
    logic [ACC_BW-1:0]       hue_acc_bin;
    logic [ACC_BW-1:0]       val_acc_bin;
    logic                    hue_acc_ok;
    logic                    val_acc_ok;
    logic [CLS_PW-1:0]       hue_cls_prod;
    logic [CLS_PW-1:0]       val_cls_prod;
    logic [CLS_BW-1:0]       hue_cls_bin;
    logic [CLS_BW-1:0]       val_cls_bin;
    logic [hvom_pkg::PIX_W-1:0] val_clamped;
    logic [HUE_AW-1:0]       hue_cls_addr;
    logic [VAL_AW-1:0]       val_cls_addr;
    logic [HUE_AW-1:0]       hue_rd_addr;
    logic [VAL_AW-1:0]       val_rd_addr;
    logic [COUNT_BITS-1:0]   hue_cnt;
    logic [COUNT_BITS-1:0]   val_cnt;
    logic                    hue_flag;
    logic                    val_flag;

    // ---------------------------------------------------------------- bins
    always_comb
    begin
        hue_acc_prod = ACC_PW'(hue) * ACC_PW'(HUE_AMUL);
        val_acc_prod = ACC_PW'(value) * ACC_PW'(VAL_AMUL);
        hue_acc_bin  = hue_acc_prod[ACC_PW-1:ACC_SHIFT];
        val_acc_bin  = val_acc_prod[ACC_PW-1:ACC_SHIFT];
        hue_acc_ok   = (9'(hue) < 9'(HUE_RANGE)) && (hue_acc_bin < ACC_BW'(HUE_BINS));
        val_acc_ok   = (9'(value) < 9'(VALUE_RANGE)) && (val_acc_bin < ACC_BW'(VALUE_BINS));

        val_clamped  = (value == hvom_pkg::VALUE_TOP) ? hvom_pkg::VALUE_CLAMP : value;
        hue_cls_prod = CLS_PW'(hue) * CLS_PW'(HUE_CRCP);
        val_cls_prod = CLS_PW'(val_clamped) * CLS_PW'(VAL_CRCP);
        hue_cls_bin  = hue_cls_prod[CLS_PW-1:CLS_SHIFT];
        val_cls_bin  = val_cls_prod[CLS_PW-1:CLS_SHIFT];

        // past the last bin clamps to it
        if (hue_cls_bin >= CLS_BW'(HUE_BINS))
            hue_cls_addr = HUE_AW'(HUE_BINS - 1);
        else
            hue_cls_addr = hue_cls_bin[HUE_AW-1:0];
        if (val_cls_bin >= CLS_BW'(VALUE_BINS))
            val_cls_addr = VAL_AW'(VALUE_BINS - 1);
        else
            val_cls_addr = val_cls_bin[VAL_AW-1:0];

        if (opcode == hvom_pkg::OP_CLASSIFY)
        begin
            hue_rd_addr = hue_cls_addr;
            val_rd_addr = val_cls_addr;
        end
        else
        begin
            hue_rd_addr = hue_acc_bin[HUE_AW-1:0];
            val_rd_addr = val_acc_bin[VAL_AW-1:0];
        end
    end

    // ---------------------------------------------------------------- fsm
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hvom_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (opcode)
                        hvom_pkg::OP_ACCUM:    state_next = hvom_pkg::ST_ACC_WR;
                        hvom_pkg::OP_CLASSIFY: state_next = hvom_pkg::ST_CLS_MUL;
                        default:               state_next = hvom_pkg::ST_IDLE;
                    endcase
                end
            end
            hvom_pkg::ST_ACC_WR:  state_next = hvom_pkg::ST_IDLE;
            hvom_pkg::ST_CLS_MUL: state_next = hvom_pkg::ST_CLS_OUT;
            hvom_pkg::ST_CLS_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = hvom_pkg::ST_IDLE;
            end
            default:              state_next = hvom_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        acc_write = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            hvom_pkg::ST_IDLE:    in_stall  = 1'b0;
            hvom_pkg::ST_ACC_WR:  acc_write = 1'b1;
            hvom_pkg::ST_CLS_MUL: in_stall  = 1'b1;
            hvom_pkg::ST_CLS_OUT: out_load  = !out_valid_reg || !out_stall;
            default:              in_stall  = 1'b1;
        endcase
    end

    assign in_accept = in_valid && !in_stall;
    assign clear_go  = in_accept && (opcode == hvom_pkg::OP_CLEAR);
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= hvom_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_thr_reg <= '0;
            val_thr_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                hvom_pkg::CFG_HUE_THR:   hue_thr_reg <= cfg_data[hvom_pkg::HUE_THR_W-1:0];
                hvom_pkg::CFG_VALUE_THR: val_thr_reg <= cfg_data[hvom_pkg::VALUE_THR_W-1:0];
                default:                 hue_thr_reg <= hue_thr_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------- memories
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            hue_rd_reg <= hue_mem[hue_rd_addr];
            val_rd_reg <= val_mem[val_rd_addr];
        end
        if (acc_write && hue_wen_reg)
            hue_mem[hue_addr_reg] <= (hue_cnt == CNT_MAX) ? CNT_MAX : hue_cnt + 1'b1;
        if (acc_write && val_wen_reg)
            val_mem[val_addr_reg] <= (val_cnt == CNT_MAX) ? CNT_MAX : val_cnt + 1'b1;
    end

    // item side-band captured with the read
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            hue_addr_reg <= hue_rd_addr;
            val_addr_reg <= val_rd_addr;
            hue_wen_reg  <= hue_acc_ok;
            val_wen_reg  <= val_acc_ok;
            hue_hit_reg  <= hue_vld_reg[hue_rd_addr];
            val_hit_reg  <= val_vld_reg[val_rd_addr];
        end
    end

    assign hue_cnt = hue_hit_reg ? hue_rd_reg : '0;
    assign val_cnt = val_hit_reg ? val_rd_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_vld_reg     <= '0;
            val_vld_reg     <= '0;
            pixel_count_reg <= '0;
        end
        else if (clear_go)
        begin
            hue_vld_reg     <= '0;
            val_vld_reg     <= '0;
            pixel_count_reg <= '0;
        end
        else if (acc_write)
        begin
            if (hue_wen_reg)
                hue_vld_reg[hue_addr_reg] <= 1'b1;
            if (val_wen_reg)
                val_vld_reg[val_addr_reg] <= 1'b1;
            if (pixel_count_reg != CNT_MAX)
                pixel_count_reg <= pixel_count_reg + 1'b1;
        end
    end

    // ---------------------------------------------------------------- classify
    always_ff @(posedge clk)
    begin
        if (state_reg == hvom_pkg::ST_CLS_MUL)
        begin
            hue_lhs_reg <= HUE_PW'(hue_cnt) * HUE_PW'(hvom_pkg::HUE_SCALE);
            hue_rhs_reg <= HUE_PW'(hue_thr_reg) * HUE_PW'(pixel_count_reg);
            val_lhs_reg <= VAL_PW'(val_cnt) * VAL_PW'(hvom_pkg::VALUE_SCALE);
            val_rhs_reg <= VAL_PW'(val_thr_reg) * VAL_PW'(pixel_count_reg);
        end
    end

    assign hue_flag = hue_lhs_reg < hue_rhs_reg;
    assign val_flag = val_lhs_reg < val_rhs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            hue_obst_reg <= hue_flag;
            val_obst_reg <= val_flag;
            mask_reg     <= (hue_flag || val_flag) ? hvom_pkg::MASK_ON : hvom_pkg::MASK_OFF;
        end
    end

    assign out_valid      = out_valid_reg;
    assign hue_obstacle   = hue_obst_reg;
    assign value_obstacle = val_obst_reg;
    assign mask           = mask_reg;

    // ---------------------------------------------------------------- checks
    `HVOM_ASSERT_NEXT(a_busy_after_work, clk, rst_n,
        in_accept && (opcode == hvom_pkg::OP_ACCUM || opcode == hvom_pkg::OP_CLASSIFY),
        in_stall, "input taken while a bin access is in flight")
    `HVOM_ASSERT_NEXT(a_clear_empties, clk, rst_n, clear_go,
        pixel_count_reg == '0 && hue_vld_reg == '0 && val_vld_reg == '0,
        "clear left histogram state behind")
    `HVOM_ASSERT_NEXT(a_result_waits, clk, rst_n,
        state_reg == hvom_pkg::ST_CLS_OUT && out_valid && out_stall,
        state_reg == hvom_pkg::ST_CLS_OUT, "classify result dropped under stall")
    `HVOM_ASSERT_IMPLY(a_mask_flags, clk, rst_n, out_valid,
        mask == ((hue_obstacle || value_obstacle) ? hvom_pkg::MASK_ON : hvom_pkg::MASK_OFF),
        "mask disagrees with obstacle flags")

endmodule

// File: tb/obstacle_mask_checker.sv
// ----------------------------------------------------------------------------
// obstacle_mask_checker
// watches the pixel, result and register channels of the obstacle mask,
// keeps its own copy of both histograms, the pixel count and the thresholds,
// and compares every classify result with the flags it worked out
// ----------------------------------------------------------------------------
module obstacle_mask_checker #(
    parameter int HUE_BINS    = 10,
    parameter int VALUE_BINS  = 15,
    parameter int HUE_RANGE   = 180,
    parameter int VALUE_RANGE = 256,
    parameter int COUNT_BITS  = 20
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [1:0]                       opcode,
    input  logic [7:0]                       hue,
    input  logic [7:0]                       value,

    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic                             hue_obstacle,
    input  logic                             value_obstacle,
    input  logic [7:0]                       mask,

    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [hvom_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hvom_pkg::CFG_DATA_W-1:0]  cfg_data,

    output int                               fail_count,
    output int                               waiting,
    output int                               results_checked
);

    import hvom_pkg::*;

    localparam int HUE_BIN_SIZE   = (HUE_RANGE / HUE_BINS) > 0 ? HUE_RANGE / HUE_BINS : 1;
    localparam int VALUE_BIN_SIZE =
        (VALUE_RANGE / VALUE_BINS) > 0 ? VALUE_RANGE / VALUE_BINS : 1;
    localparam longint unsigned HUE_PER_COUNT   = 100000;
    localparam longint unsigned VALUE_PER_COUNT = 1000;
    localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;
    localparam logic [7:0] MASK_SET   = 8'd255;
    localparam logic [7:0] MASK_CLEAR = 8'd0;
    localparam logic [7:0] BRIGHT_TOP = 8'd255;
    localparam logic [7:0] BRIGHT_CAP = 8'd254;

    typedef struct packed {
        logic       hue_obs;
        logic       value_obs;
        logic [7:0] mask;
    } obstacle_flags_t;

    logic [COUNT_BITS-1:0] hue_bins [HUE_BINS];
    logic [COUNT_BITS-1:0] value_bins [VALUE_BINS];
    logic [COUNT_BITS-1:0] pixels;
    logic [HUE_THR_W-1:0]   hue_thr;
    logic [VALUE_THR_W-1:0] value_thr;

    obstacle_flags_t expected_flags [$];

    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
        return (c == COUNT_TOP) ? c : c + 1'b1;
    endfunction

    function automatic obstacle_flags_t classify_pixel(input logic [7:0] h,
                                                       input logic [7:0] v);
        obstacle_flags_t r;
        int unsigned     hb;
        int unsigned     vb;
        logic [7:0]      vc;
        hb = h / HUE_BIN_SIZE;
        if (hb >= HUE_BINS)
            hb = HUE_BINS - 1;
        vc = (v == BRIGHT_TOP) ? BRIGHT_CAP : v;
        vb = vc / VALUE_BIN_SIZE;
        if (vb >= VALUE_BINS)
            vb = VALUE_BINS - 1;
        r.hue_obs   = (64'(hue_bins[hb]) * HUE_PER_COUNT) < (64'(hue_thr) * 64'(pixels));
        r.value_obs = (64'(value_bins[vb]) * VALUE_PER_COUNT)
                      < (64'(value_thr) * 64'(pixels));
        r.mask      = (r.hue_obs || r.value_obs) ? MASK_SET : MASK_CLEAR;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        obstacle_flags_t want;
        int unsigned     bin;
        if (!rst_n)
        begin
            foreach (hue_bins[i])
                hue_bins[i] = '0;
            foreach (value_bins[i])
                value_bins[i] = '0;
            pixels    = '0;
            hue_thr   = '0;
            value_thr = '0;
            expected_flags.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_flags.size() == 0)
                begin
                    $error("result item with no classify pending: hue_obstacle %0d value_obstacle %0d mask %0d",
                           hue_obstacle, value_obstacle, mask);
                    fail_count++;
                end
                else
                begin
                    want = expected_flags.pop_front();
                    if (hue_obstacle !== want.hue_obs)
                    begin
                        $error("hue_obstacle: expected %0d, got %0d", want.hue_obs, hue_obstacle);
                        fail_count++;
                    end
                    if (value_obstacle !== want.value_obs)
                    begin
                        $error("value_obstacle: expected %0d, got %0d",
                               want.value_obs, value_obstacle);
                        fail_count++;
                    end
                    if (mask !== want.mask)
                    begin
                        $error("mask: expected %0d, got %0d", want.mask, mask);
                        fail_count++;
                    end
                    results_checked++;
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_HUE_THR:   hue_thr   = cfg_data[HUE_THR_W-1:0];
                    CFG_VALUE_THR: value_thr = cfg_data[VALUE_THR_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                case (opcode)
                    OP_CLEAR:
                    begin
                        foreach (hue_bins[i])
                            hue_bins[i] = '0;
                        foreach (value_bins[i])
                            value_bins[i] = '0;
                        pixels = '0;
                    end
                    OP_ACCUM:
                    begin
                        pixels = bump(pixels);
                        // samples past the range still count as pixels
                        if (int'(hue) < HUE_RANGE)
                        begin
                            bin = (int'(hue) * HUE_BINS) / HUE_RANGE;
                            if (bin < HUE_BINS)
                                hue_bins[bin] = bump(hue_bins[bin]);
                        end
                        if (int'(value) < VALUE_RANGE)
                        begin
                            bin = (int'(value) * VALUE_BINS) / VALUE_RANGE;
                            if (bin < VALUE_BINS)
                                value_bins[bin] = bump(value_bins[bin]);
                        end
                    end
                    OP_CLASSIFY:
                        expected_flags.push_back(classify_pixel(hue, value));
                    default: ;
                endcase
            end
        end
        waiting = expected_flags.size();
    end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus for the hue/value histogram obstacle mask: directed pixels at the
// field limits and bin edges, then frames of clustered random pixels under
// several threshold settings, with bursty input and a stalling output side
// ----------------------------------------------------------------------------
module tb;

    import hvom_pkg::*;

    // narrow counters so that saturation is reachable within the run
    localparam int COUNT_BITS     = 8;
    localparam int IDLE_LIMIT     = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 60;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       in_valid;
    logic       in_stall;
    logic [1:0] opcode;
    logic [7:0] hue;
    logic [7:0] value;

    logic       out_valid;
    logic       out_stall;
    logic       hue_obstacle;
    logic       value_obstacle;
    logic [7:0] mask;

    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int fail_count;
    int waiting;
    int results_checked;

    int  burst_left = 8;
    bit  no_gaps = 1'b0;
    bit  long_hold_req = 1'b0;
    int  n_clear, n_accum, n_classify, n_unused, n_settings;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    hue_value_histogram_obstacle_mask #(.COUNT_BITS(COUNT_BITS)) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .hue            (hue),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hue_obstacle   (hue_obstacle),
        .value_obstacle (value_obstacle),
        .mask           (mask),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    obstacle_mask_checker #(.COUNT_BITS(COUNT_BITS)) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .hue             (hue),
        .value           (value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .hue_obstacle    (hue_obstacle),
        .value_obstacle  (value_obstacle),
        .mask            (mask),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .waiting         (waiting),
        .results_checked (results_checked)
    );

    // result side: stall modes that change every so often, one long hold-off
    initial
    begin : result_side
        int  mode;
        int  mode_left;
        bit  hold_done;
        mode      = 0;
        mode_left = 0;
        hold_done = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 99) < 25);
                    2: out_stall <= ($urandom_range(0, 99) < 75);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("no handshake for %0d cycles", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    task automatic pause(input int n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic send_item(input logic [1:0] op, input logic [7:0] h, input logic [7:0] v);
        @(negedge clk);
        in_valid <= 1'b1;
        opcode   <= op;
        hue      <= h;
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        case (op)
            OP_CLEAR:    n_clear++;
            OP_ACCUM:    n_accum++;
            OP_CLASSIFY: n_classify++;
            default:     n_unused++;
        endcase
        if (!no_gaps)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                pause($urandom_range(1, 12));
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    // let every classify drain and any accumulate finish before a register write
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (waiting == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one frame: usually a clear, then pixels clustered around one hot color
    task automatic run_frame(input int n, input bit saturate);
        logic [7:0] hot_h;
        logic [7:0] hot_v;
        logic [7:0] h;
        logic [7:0] v;
        logic [1:0] op;
        int         r;
        hot_h = 8'($urandom_range(0, 179));
        hot_v = 8'($urandom_range(0, 255));
        if (!saturate && $urandom_range(0, 99) < 85)
            send_item(OP_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (saturate)
                op = (r < 90) ? OP_ACCUM : OP_CLASSIFY;
            else if (r < 55)
                op = OP_ACCUM;
            else if (r < 88)
                op = OP_CLASSIFY;
            else if (r < 94)
                op = OP_UNUSED;
            else
                op = OP_CLEAR;
            r = $urandom_range(0, 99);
            if (saturate || r < 55)
            begin
                h = hot_h;
                v = hot_v;
            end
            else if (r < 85)
            begin
                h = 8'($urandom_range(0, 179));
                v = 8'($urandom_range(0, 255));
            end
            else
            begin
                h = 8'($urandom_range(0, 255));
                v = 8'($urandom_range(0, 255));
            end
            // classify anywhere half the time so rare bins get looked at
            if (op == OP_CLASSIFY && $urandom_range(0, 1) == 1)
            begin
                h = 8'($urandom_range(0, 255));
                v = 8'($urandom_range(0, 255));
            end
            send_item(op, h, v);
        end
    endtask

    initial
    begin : stimulus
        int                    ph;
        int                    phase_start;
        logic [HUE_THR_W-1:0]  ht;
        logic [CFG_DATA_W-1:0] vt;
        in_valid  = 1'b0;
        opcode    = OP_CLEAR;
        hue       = '0;
        value     = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_HUE_THR;
        cfg_data  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty histograms at reset thresholds
        send_item(OP_CLASSIFY, 8'd0, 8'd0);
        drain();
        write_reg(CFG_HUE_THR, 14'd10000);
        write_reg(CFG_VALUE_THR, 14'd100);
        n_settings = 2;

        send_item(OP_CLASSIFY, 8'd179, 8'd255);
        send_item(OP_ACCUM, 8'd0, 8'd0);
        send_item(OP_ACCUM, 8'd179, 8'd255);
        send_item(OP_ACCUM, 8'd180, 8'd0);     // hue just past its range
        send_item(OP_ACCUM, 8'd255, 8'd255);
        send_item(OP_ACCUM, 8'd90, 8'd128);
        send_item(OP_ACCUM, 8'd90, 8'd128);
        send_item(OP_UNUSED, 8'd255, 8'd255);
        send_item(OP_CLASSIFY, 8'd0, 8'd0);
        send_item(OP_CLASSIFY, 8'd179, 8'd254);
        send_item(OP_CLASSIFY, 8'd255, 8'd255); // both bins clamp to the last
        send_item(OP_CLASSIFY, 8'd200, 8'd100);
        send_item(OP_CLASSIFY, 8'd17, 8'd16);
        send_item(OP_CLASSIFY, 8'd18, 8'd17);
        send_item(OP_CLASSIFY, 8'd90, 8'd128);
        send_item(OP_CLEAR, 8'd255, 8'd255);
        send_item(OP_CLASSIFY, 8'd0, 8'd0);
        repeat (3)
            send_item(OP_ACCUM, 8'd100, 8'd200);
        send_item(OP_CLASSIFY, 8'd100, 8'd200);
        send_item(OP_CLASSIFY, 8'd50, 8'd50);

        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    ht = 14'h3FFF;
                    vt = 14'h3FFF;
                end
                1:
                begin
                    ht = '0;
                    vt = '0;
                end
                2:
                begin
                    ht = 14'd10000;
                    vt = 14'd100;
                end
                default:
                begin
                    ht = 14'($urandom_range(0, 16383));
                    vt = 14'($urandom_range(0, 16383));
                end
            endcase
            drain();
            write_reg(CFG_HUE_THR, ht);
            write_reg(CFG_VALUE_THR, vt);
            n_settings++;
            no_gaps = (ph == 1);
            if (ph == 2)
                long_hold_req = 1'b1;
            phase_start = n_clear + n_accum + n_classify + n_unused;
            while (n_clear + n_accum + n_classify + n_unused - phase_start < PHASE_ITEMS)
                run_frame($urandom_range(4, 30), 1'b0);
            if (ph == 3)
                run_frame(320, 1'b1);
        end

        drain();
        repeat (8) @(posedge clk);
        $display("sent %0d items: %0d clear, %0d accumulate, %0d classify, %0d unused opcode",
                 n_clear + n_accum + n_classify + n_unused, n_clear, n_accum, n_classify,
                 n_unused);
        $display("checked %0d classify results over %0d threshold settings, %0d-bit counters",
                 results_checked, n_settings, COUNT_BITS);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
